@@ rtl/vqap_pkg.sv @@
package vqap_pkg;

  localparam int KIND_W    = 3;
  localparam int SIZE_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int ERR_W     = 2;
  localparam int WORD_W    = 16;
  localparam int ARG_DEPTH = 32;
  localparam int ARG_AW    = $clog2(ARG_DEPTH);
  localparam int ARGC_W    = ARG_AW + 1;
  localparam int GRP_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_COPY    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOTION  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SOLID   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PATTERN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUAD    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SPLIT   = 3'd5;

  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MOTION = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DEAD   = 2'd2;

  localparam logic [1:0] ACT_COPY   = 2'd0;
  localparam logic [1:0] ACT_MOTION = 2'd1;
  localparam logic [1:0] ACT_VQ     = 2'd2;
  localparam logic [1:0] ACT_SPLIT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_Y = 1'b1;

  localparam logic [GRP_W-1:0] GROUP_FULL = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0] cell_kind;
    logic [SIZE_W-1:0] cell_size;
    logic [BYTE_W-1:0] index_a;
    logic [BYTE_W-1:0] index_b;
    logic [BYTE_W-1:0] index_c;
    logic [BYTE_W-1:0] index_d;
    logic [BYTE_W-1:0] motion_x_raw;
    logic [BYTE_W-1:0] motion_y_raw;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic [ERR_W-1:0]  cell_error;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic push;
    logic align;
    logic load_err;
    logic load_flush;
  } vqap_cmd_t;

  typedef struct packed {
    logic             size_ok;
    logic [ERR_W-1:0] err;
    logic             nargs_zero;
    logic             push_last;
    logic             frame_end;
    logic             group_zero;
    logic             group_full;
    logic             out_free;
    logic             flush_last;
  } vqap_status_t;

endpackage

@@ rtl/vqap_if.sv @@
interface vqap_in_if;
  import vqap_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] cell_kind;
  logic [SIZE_W-1:0] cell_size;
  logic [BYTE_W-1:0] index_a;
  logic [BYTE_W-1:0] index_b;
  logic [BYTE_W-1:0] index_c;
  logic [BYTE_W-1:0] index_d;
  logic [BYTE_W-1:0] motion_x_raw;
  logic [BYTE_W-1:0] motion_y_raw;
  logic              frame_end;

  modport source (
    output valid, cell_kind, cell_size, index_a, index_b, index_c, index_d,
           motion_x_raw, motion_y_raw, frame_end,
    input  ready
  );
  modport sink (
    input  valid, cell_kind, cell_size, index_a, index_b, index_c, index_d,
           motion_x_raw, motion_y_raw, frame_end,
    output ready
  );
endinterface

interface vqap_out_if;
  import vqap_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic [ERR_W-1:0]  cell_error;

  modport source (output valid, out_byte, last_of_run, cell_error, input ready);
  modport sink   (input valid, out_byte, last_of_run, cell_error, output ready);
endinterface

@@ rtl/vq_cell_action_packer_core.sv @@
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    cell_kind, cell_size, index_a..d, motion_x/y_raw, frame_end
// out_chan  out  valid/ready    out_byte, last_of_run, cell_error
// cfg_*     in   cfg_we only    cfg_index selects mean_motion_x or mean_motion_y
//
// One item at a time: accept, evaluate, write each argument byte (0, 1 or 4) through
// the single write port of the argument buffer, decide, then, when a group flushes,
// send each output byte (2 + buffered arguments). A skipped or copy cell that closes
// no group passes accept, evaluate and decide; the byte-wide output sets the flush length.
// Reset is synchronous; the argument buffer needs no clearing pass.
// Output stalls hold the controller in place; the output register frees in_ready's path.
module vq_cell_action_packer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  vqap_in_if.sink                          in_chan,
  vqap_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [vqap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vqap_pkg::BYTE_W-1:0]      cfg_wdata
);
  import vqap_pkg::*;

  vqap_cmd_t    cmd;
  vqap_status_t status;
  in_item_t     in_item;
  out_item_t    out_item;
  logic         in_ready;
  logic         out_valid;

  assign in_item.cell_kind    = in_chan.cell_kind;
  assign in_item.cell_size    = in_chan.cell_size;
  assign in_item.index_a      = in_chan.index_a;
  assign in_item.index_b      = in_chan.index_b;
  assign in_item.index_c      = in_chan.index_c;
  assign in_item.index_d      = in_chan.index_d;
  assign in_item.motion_x_raw = in_chan.motion_x_raw;
  assign in_item.motion_y_raw = in_chan.motion_y_raw;
  assign in_item.frame_end    = in_chan.frame_end;
  assign in_chan.ready        = in_ready;

  assign out_chan.valid       = out_valid;
  assign out_chan.out_byte    = out_item.out_byte;
  assign out_chan.last_of_run = out_item.last_of_run;
  assign out_chan.cell_error  = out_item.cell_error;

  vqap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vqap_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

endmodule

@@ rtl/vqap_ctrl.sv @@
module vqap_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vqap_pkg::vqap_status_t status,
  output vqap_pkg::vqap_cmd_t    cmd
);
  import vqap_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH,
    S_POST,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status.size_ok) begin
          state_nxt = S_POST;
        end else if (status.err != ERR_NONE) begin
          if (status.out_free) begin
            cmd.load_err = 1'b1;
            state_nxt    = S_POST;
          end
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = status.nargs_zero ? S_POST : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (status.push_last) state_nxt = S_POST;
      end
      S_POST: begin
        if (status.group_full) begin
          state_nxt = S_FLUSH;
        end else if (status.frame_end && !status.group_zero) begin
          // A partial group is left-aligned before it goes out.
          cmd.align = 1'b1;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.load_flush = 1'b1;
          if (status.flush_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/vqap_datapath.sv @@
module vqap_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vqap_pkg::in_item_t                in_item,
  input  logic                              cfg_we,
  input  logic [vqap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vqap_pkg::BYTE_W-1:0]       cfg_wdata,
  input  vqap_pkg::vqap_cmd_t               cmd,
  output vqap_pkg::vqap_status_t            status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vqap_pkg::out_item_t               out_item
);
  import vqap_pkg::*;

  in_item_t            cell_r;
  logic [BYTE_W-1:0]   mean_x_r, mean_y_r;
  logic [WORD_W-1:0]   word_r;
  logic [GRP_W-1:0]    group_r;
  logic [ARGC_W-1:0]   argc_r;
  logic [1:0]          pidx_r;
  logic [ARGC_W-1:0]   fidx_r;
  logic [BYTE_W-1:0]   arg_mem [ARG_DEPTH];
  logic [BYTE_W-1:0]   rdata_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [9:0]          dx, dy;
  logic                motion_ok;
  logic [BYTE_W-1:0]   motion_byte;
  logic [ERR_W-1:0]    err;
  logic [1:0]          code;
  logic                nargs_zero;
  logic                is_quad;
  logic [BYTE_W-1:0]   push_byte;
  logic [GRP_W-1:0]    align_gap;
  logic [3:0]          shamt;
  logic [ARGC_W-1:0]   fidx_after, rd_idx;
  logic                flush_last;
  logic                out_free;
  logic [BYTE_W-1:0]   flush_byte;

  // Offset = raw - 128 - mean + 8; in range only when the upper bits are all zero.
  assign dx = {2'b00, cell_r.motion_x_raw} - 10'd120 - {{2{mean_x_r[7]}}, mean_x_r};
  assign dy = {2'b00, cell_r.motion_y_raw} - 10'd120 - {{2{mean_y_r[7]}}, mean_y_r};
  assign motion_ok   = (dx[9:4] == 6'd0) && (dy[9:4] == 6'd0);
  assign motion_byte = {dx[3:0], dy[3:0]};

  always_comb begin
    err        = ERR_NONE;
    code       = ACT_COPY;
    nargs_zero = 1'b1;
    case (cell_r.cell_kind) inside
      KIND_COPY: begin
        code = ACT_COPY;
      end
      KIND_MOTION: begin
        code       = ACT_MOTION;
        nargs_zero = 1'b0;
        if (!motion_ok) err = ERR_MOTION;
      end
      KIND_SOLID, KIND_PATTERN: begin
        code       = ACT_VQ;
        nargs_zero = 1'b0;
      end
      KIND_QUAD: begin
        code       = ACT_SPLIT;
        nargs_zero = 1'b0;
      end
      KIND_SPLIT: begin
        code = ACT_SPLIT;
      end
      default: begin
        err = ERR_DEAD;
      end
    endcase
  end

  assign is_quad = (cell_r.cell_kind == KIND_QUAD);

  always_comb begin
    push_byte = cell_r.index_a;
    if (cell_r.cell_kind == KIND_MOTION) begin
      push_byte = motion_byte;
    end else if (is_quad) begin
      case (pidx_r)
        2'd0:    push_byte = cell_r.index_a;
        2'd1:    push_byte = cell_r.index_b;
        2'd2:    push_byte = cell_r.index_c;
        default: push_byte = cell_r.index_d;
      endcase
    end
  end

  assign align_gap = GROUP_FULL - group_r;
  assign shamt     = {align_gap[2:0], 1'b0};

  // Byte 0 and 1 of a flush are the action word; the rest come from the buffer.
  assign flush_last = (fidx_r == argc_r + ARGC_W'(1));
  assign fidx_after = cmd.load_flush ? fidx_r + ARGC_W'(1) : fidx_r;
  assign rd_idx     = fidx_after - ARGC_W'(2);

  always_comb begin
    case (fidx_r)
      ARGC_W'(0): flush_byte = word_r[7:0];
      ARGC_W'(1): flush_byte = word_r[15:8];
      default:    flush_byte = rdata_r;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  assign status.size_ok    = (cell_r.cell_size != '0) && !cell_r.cell_size[SIZE_W-1];
  assign status.err        = err;
  assign status.nargs_zero = nargs_zero;
  assign status.push_last  = is_quad ? (pidx_r == 2'd3) : 1'b1;
  assign status.frame_end  = cell_r.frame_end;
  assign status.group_zero = (group_r == '0);
  assign status.group_full = (group_r == GROUP_FULL);
  assign status.out_free   = out_free;
  assign status.flush_last = flush_last;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_x_r    <= '0;
      mean_y_r    <= '0;
      word_r      <= '0;
      group_r     <= '0;
      argc_r      <= '0;
      pidx_r      <= '0;
      fidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEAN_X: mean_x_r <= cfg_wdata;
          CFG_MEAN_Y: mean_y_r <= cfg_wdata;
          default:    mean_x_r <= mean_x_r;
        endcase
      end
      if (cmd.capture) begin
        pidx_r <= '0;
        fidx_r <= '0;
      end
      if (cmd.commit) begin
        word_r  <= {word_r[WORD_W-3:0], code};
        group_r <= group_r + GRP_W'(1);
      end
      if (cmd.align) word_r <= word_r << shamt;
      if (cmd.push) begin
        argc_r <= argc_r + ARGC_W'(1);
        pidx_r <= pidx_r + 2'd1;
      end
      if (cmd.load_flush) begin
        fidx_r <= fidx_after;
        if (flush_last) begin
          word_r  <= '0;
          group_r <= '0;
          argc_r  <= '0;
        end
      end
      if (cmd.load_err || cmd.load_flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) cell_r <= in_item;
    if (cmd.push) arg_mem[argc_r[ARG_AW-1:0]] <= push_byte;
    rdata_r <= arg_mem[rd_idx[ARG_AW-1:0]];
    if (cmd.load_err) begin
      out_r.out_byte    <= '0;
      out_r.last_of_run <= !(cell_r.frame_end && (group_r != '0));
      out_r.cell_error  <= err;
    end else if (cmd.load_flush) begin
      out_r.out_byte    <= flush_byte;
      out_r.last_of_run <= flush_last;
      out_r.cell_error  <= ERR_NONE;
    end
  end

endmodule
